### src/dtc_response_collector_assert.svh
// ----------------------------------------------------------------------------
// dtc_response_collector_assert.svh
// Assertion macros for the trouble code collector.
// ----------------------------------------------------------------------------
`ifndef DTC_RESPONSE_COLLECTOR_ASSERT_SVH
`define DTC_RESPONSE_COLLECTOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define DTC_ASSERT_HOLD(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("dtc_response_collector: invariant violated");
`define DTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) ante |=> cons) \
        else $error("dtc_response_collector: sequence violated");
`else
`define DTC_ASSERT_HOLD(lbl, clk, rstn, prop)
`define DTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### src/dtc_pkg.sv
// ----------------------------------------------------------------------------
// dtc_pkg
// Shared types and constants of the trouble code collector.
// ----------------------------------------------------------------------------
package dtc_pkg;

    localparam int          MAX_CODES_DEF  = 16;
    localparam int          NUM_LANES      = 3;

    localparam logic [10:0] ID_LOW         = 11'h7E8;
    localparam logic [10:0] ID_HIGH        = 11'h7EF;
    localparam logic [7:0]  SERVICE_OFFSET = 8'h40;
    localparam logic [7:0]  BYTE_INVALID   = 8'hFF;
    localparam logic [7:0]  MODE_RESET     = 8'h03;
    localparam logic [3:0]  MIN_LENGTH     = 4'd3;
    localparam logic [3:0]  MAX_PAYLOAD    = 4'd7;

    localparam logic        CMD_START      = 1'b0;
    localparam logic        CMD_FRAME      = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [10:0] frame_id;
        logic [3:0]  frame_length;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [7:0]  byte3;
        logic [7:0]  byte4;
        logic [7:0]  byte5;
        logic [7:0]  byte6;
        logic [7:0]  byte7;
    } t_in;

    typedef struct packed {
        logic        frame_accepted;
        logic [1:0]  codes_added;
        logic [4:0]  total_codes;
        logic        list_full;
        logic [15:0] new_code_first;
        logic [15:0] new_code_second;
        logic [15:0] new_code_third;
    } t_out;

    // candidate still eligible after the store walk
    typedef struct packed {
        logic        cand;
        logic [15:0] code;
    } t_lane_stat;

    typedef struct packed {
        logic [1:0]  added;
        logic [15:0] code0;
        logic [15:0] code1;
        logic [15:0] code2;
    } t_merge;

endpackage

### src/dtc_lane.sv
// ----------------------------------------------------------------------------
// dtc_lane
// One code pair: holds the candidate and flags a match against stored codes.
// ----------------------------------------------------------------------------
module dtc_lane (
    input  logic                  i_clk,
    input  logic                  i_load,
    input  logic                  i_ok,
    input  logic [15:0]           i_code,
    input  logic                  i_cmp_vld,
    input  logic [15:0]           i_cmp_data,
    output dtc_pkg::t_lane_stat   o_stat
);
    import dtc_pkg::*;

    logic        r_ok;
    logic        r_dup;
    logic [15:0] r_code;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ok   <= i_ok;
            r_code <= i_code;
            r_dup  <= 1'b0;
        end else if (i_cmp_vld && (i_cmp_data == r_code)) begin
            r_dup <= 1'b1;
        end
    end

    assign o_stat.cand = r_ok && !r_dup;
    assign o_stat.code = r_code;

endmodule

### src/dtc_merge.sv
// ----------------------------------------------------------------------------
// dtc_merge
// Combines lane results in pair order: in-frame duplicates and list capacity.
// ----------------------------------------------------------------------------
module dtc_merge #(
    parameter int MAX_CODES = dtc_pkg::MAX_CODES_DEF,
    parameter int CNT_W     = $clog2(MAX_CODES + 1)
) (
    input  logic [CNT_W-1:0]    i_count,
    input  dtc_pkg::t_lane_stat i_lane [dtc_pkg::NUM_LANES],
    output dtc_pkg::t_merge     o_merge
);
    import dtc_pkg::*;

    localparam int               SUM_W = CNT_W + 2;
    localparam logic [SUM_W-1:0] MAX_V = SUM_W'(MAX_CODES);

    logic [SUM_W-1:0] base;
    logic             take0;
    logic             take1;
    logic             take2;

    always_comb begin
        base  = SUM_W'(i_count);
        take0 = i_lane[0].cand && (base < MAX_V);
        take1 = i_lane[1].cand
                && !(take0 && (i_lane[1].code == i_lane[0].code))
                && ((base + SUM_W'(take0)) < MAX_V);
        take2 = i_lane[2].cand
                && !(take0 && (i_lane[2].code == i_lane[0].code))
                && !(take1 && (i_lane[2].code == i_lane[1].code))
                && ((base + SUM_W'(take0) + SUM_W'(take1)) < MAX_V);

        o_merge.added = 2'(take0) + 2'(take1) + 2'(take2);

        if (take0) begin
            o_merge.code0 = i_lane[0].code;
        end else if (take1) begin
            o_merge.code0 = i_lane[1].code;
        end else if (take2) begin
            o_merge.code0 = i_lane[2].code;
        end else begin
            o_merge.code0 = '0;
        end

        if (take0 && take1) begin
            o_merge.code1 = i_lane[1].code;
        end else if ((take0 ^ take1) && take2) begin
            o_merge.code1 = i_lane[2].code;
        end else begin
            o_merge.code1 = '0;
        end

        o_merge.code2 = (take0 && take1 && take2) ? i_lane[2].code : 16'h0000;
    end

endmodule

### src/dtc_response_collector.sv
// Flow: a start command or a rejected frame goes from idle straight to the done
// state, which registers the result; an accepted frame scans the stored codes,
// merges the lane results and writes the added codes before done. A stalled
// result holds the done state. One item at a time: input is ready only in idle,
// so the next item waits; the one-port store walk and code writes set the pace.
// Reset (synchronous, active low): list empty, request_mode 3, no result.
// ----------------------------------------------------------------------------
// dtc_response_collector
// Collects trouble codes from diagnostic reply frames into a code list.
// ----------------------------------------------------------------------------
`include "dtc_response_collector_assert.svh"

module dtc_response_collector #(
    parameter int MAX_CODES = dtc_pkg::MAX_CODES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  dtc_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output dtc_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_wdata
);
    import dtc_pkg::*;

    localparam int CNT_W = $clog2(MAX_CODES + 1);
    localparam int IDX_W = (MAX_CODES > 1) ? $clog2(MAX_CODES) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MERGE,
        ST_WRITE,
        ST_DONE
    } t_state;

    t_state           r_state;
    logic [7:0]       r_mode;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_idx;
    logic             r_rd_vld;
    logic [15:0]      r_rdata;
    logic             r_acc;
    logic [1:0]       r_added;
    logic [1:0]       r_wsel;
    logic [15:0]      r_new [NUM_LANES];
    logic             r_out_vld;
    t_out             r_out;

    logic [15:0]      mem [MAX_CODES];

    logic             in_xfer;
    logic             full;
    logic             frame_ok;
    logic [3:0]       payload;
    logic [15:0]      pair_code [NUM_LANES];
    logic             pair_ok [NUM_LANES];
    t_lane_stat       lane_stat [NUM_LANES];
    t_merge           merge;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign full       = (r_count >= CNT_W'(MAX_CODES));
    assign payload    = i_in_data.byte0[3:0];

    always_comb begin
        frame_ok = (i_in_data.cmd == CMD_FRAME) && !full
                   && (i_in_data.frame_id >= ID_LOW) && (i_in_data.frame_id <= ID_HIGH)
                   && (i_in_data.frame_length >= MIN_LENGTH)
                   && (i_in_data.byte0[7:4] == 4'h0)
                   && (payload != 4'h0) && (payload <= MAX_PAYLOAD)
                   && (i_in_data.byte1 == 8'(SERVICE_OFFSET + r_mode));

        pair_code[0] = {i_in_data.byte2, i_in_data.byte3};
        pair_code[1] = {i_in_data.byte4, i_in_data.byte5};
        pair_code[2] = {i_in_data.byte6, i_in_data.byte7};

        for (int k = 0; k < NUM_LANES; k++) begin
            pair_ok[k] = frame_ok
                         && (payload >= 4'(2 + 2 * k))
                         && (i_in_data.frame_length > 4'(3 + 2 * k))
                         && (pair_code[k] != 16'h0000)
                         && (pair_code[k][15:8] != BYTE_INVALID)
                         && (pair_code[k][7:0] != BYTE_INVALID);
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        dtc_lane u_lane (
            .i_clk      (i_clk),
            .i_load     (in_xfer),
            .i_ok       (pair_ok[g]),
            .i_code     (pair_code[g]),
            .i_cmp_vld  (r_rd_vld),
            .i_cmp_data (r_rdata),
            .o_stat     (lane_stat[g])
        );
    end

    dtc_merge #(
        .MAX_CODES (MAX_CODES),
        .CNT_W     (CNT_W)
    ) u_merge (
        .i_count (r_count),
        .i_lane  (lane_stat),
        .o_merge (merge)
    );

    // code store
    always_ff @(posedge i_clk) begin
        if (r_state == ST_WRITE && r_wsel != r_added) begin
            mem[r_count[IDX_W-1:0]] <= r_new[r_wsel];
        end
        if (r_state == ST_SCAN && r_idx < r_count) begin
            r_rdata <= mem[r_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_mode    <= MODE_RESET;
            r_count   <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (r_out_vld && i_out_ready && (r_state != ST_DONE)) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_acc    <= frame_ok;
                        r_added  <= 2'd0;
                        r_wsel   <= 2'd0;
                        r_idx    <= '0;
                        r_rd_vld <= 1'b0;
                        for (int k = 0; k < NUM_LANES; k++) begin
                            r_new[k] <= '0;
                        end
                        if (i_in_data.cmd == CMD_START) begin
                            r_count <= '0;
                        end
                        r_state <= frame_ok ? ST_SCAN : ST_DONE;
                    end
                end
                ST_SCAN: begin
                    if (r_idx < r_count) begin
                        r_rd_vld <= 1'b1;
                        r_idx    <= r_idx + 1'b1;
                    end else begin
                        r_rd_vld <= 1'b0;
                        if (!r_rd_vld) begin
                            r_state <= ST_MERGE;
                        end
                    end
                end
                ST_MERGE: begin
                    r_added  <= merge.added;
                    r_new[0] <= merge.code0;
                    r_new[1] <= merge.code1;
                    r_new[2] <= merge.code2;
                    r_state  <= ST_WRITE;
                end
                ST_WRITE: begin
                    if (r_wsel != r_added) begin
                        r_count <= r_count + 1'b1;
                        r_wsel  <= r_wsel + 1'b1;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_vld || i_out_ready) begin
                        r_out_vld             <= 1'b1;
                        r_out.frame_accepted  <= r_acc;
                        r_out.codes_added     <= r_added;
                        r_out.total_codes     <= 5'(r_count);
                        r_out.list_full       <= full;
                        r_out.new_code_first  <= r_new[0];
                        r_out.new_code_second <= r_new[1];
                        r_out.new_code_third  <= r_new[2];
                        r_state               <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `DTC_ASSERT_HOLD(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(MAX_CODES))
    `DTC_ASSERT_HOLD(a_reject_adds_none, i_clk, i_rst_n,
        (o_out_valid && !o_out_data.frame_accepted) |-> (o_out_data.codes_added == 2'd0))
    `DTC_ASSERT_NEXT(a_start_clears, i_clk, i_rst_n,
        (in_xfer && (i_in_data.cmd == CMD_START)), (r_count == '0))
    `DTC_ASSERT_NEXT(a_write_grows, i_clk, i_rst_n,
        ((r_state == ST_WRITE) && (r_wsel != r_added)), (r_count == $past(r_count) + 1'b1))

endmodule

### bench/tb_dtc_response_collector.sv
// ----------------------------------------------------------------------------
// tb_dtc_response_collector
// Self-checking bench for the trouble code collector: a directed table of
// filter corner cases and list fill, then randomized query sequences under
// several request modes, scored against a cycle-free code list model.
// ----------------------------------------------------------------------------
module tb_dtc_response_collector;
    import dtc_pkg::*;

    localparam int MAX_CODES  = MAX_CODES_DEF;
    localparam int CYCLE_CAP  = 200000;
    localparam int PHASE_LEN  = 68;

    typedef struct {
        t_in  item;
        bit   typed;
        t_out reply;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in         in_data;
    logic        out_valid;
    logic        out_ready;
    t_out        out_data;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;

    logic [7:0]  req_mode;
    logic [15:0] code_list [0:MAX_CODES-1];
    int unsigned code_count;

    t_out        replies [$];
    t_row        table_rows [$];
    bit          gap_on;
    bit          stall_on;
    int unsigned n_fail;
    int unsigned n_items;
    int unsigned n_checked;
    int unsigned n_fills;
    int unsigned n_modes;

    dtc_response_collector #(
        .MAX_CODES (MAX_CODES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_CAP) @(posedge i_clk);
        $display("Timeout after %0d cycles, %0d results pending", CYCLE_CAP, replies.size());
        $display("Test completed with failures");
        $finish;
    end

    // code list model: updates state, returns the reply to one transfer
    function automatic t_out collect_codes(t_in it);
        t_out        r;
        logic [7:0]  d [0:7];
        logic [7:0]  svc;
        logic [15:0] code;
        int unsigned payload;
        int unsigned flen;
        int unsigned pos;
        bit          dup;
        r       = '0;
        d[0]    = it.byte0;
        d[1]    = it.byte1;
        d[2]    = it.byte2;
        d[3]    = it.byte3;
        d[4]    = it.byte4;
        d[5]    = it.byte5;
        d[6]    = it.byte6;
        d[7]    = it.byte7;
        svc     = SERVICE_OFFSET + req_mode;
        payload = 32'(it.byte0[3:0]);
        flen    = 32'(it.frame_length);
        if (it.cmd == CMD_START) begin
            code_count = 0;
        end else if (code_count < MAX_CODES && it.frame_id >= ID_LOW
                     && it.frame_id <= ID_HIGH && it.frame_length >= MIN_LENGTH
                     && it.byte0[7:4] == 4'h0 && payload >= 1
                     && payload <= 32'(MAX_PAYLOAD) && it.byte1 == svc) begin
            r.frame_accepted = 1'b1;
            for (pos = 2; pos <= 6 && pos + 1 <= payload + 1 && pos + 1 < flen; pos += 2) begin
                if (!((d[pos] == 8'h00 && d[pos+1] == 8'h00) || d[pos] == BYTE_INVALID
                      || d[pos+1] == BYTE_INVALID)) begin
                    code = {d[pos], d[pos+1]};
                    dup  = 1'b0;
                    for (int k = 0; k < code_count; k++)
                        if (code_list[k] == code) dup = 1'b1;
                    if (!dup && code_count < MAX_CODES) begin
                        code_list[code_count] = code;
                        code_count++;
                        if (code_count == MAX_CODES) n_fills++;
                        case (r.codes_added)
                            2'd0:    r.new_code_first  = code;
                            2'd1:    r.new_code_second = code;
                            default: r.new_code_third  = code;
                        endcase
                        r.codes_added = r.codes_added + 2'd1;
                    end
                end
            end
        end
        r.total_codes = code_count[4:0];
        r.list_full   = (code_count >= MAX_CODES);
        return r;
    endfunction

    function automatic t_in frame(logic [10:0] id, logic [3:0] len, logic [7:0] b0,
                                  logic [7:0] b1, logic [7:0] b2, logic [7:0] b3,
                                  logic [7:0] b4, logic [7:0] b5, logic [7:0] b6,
                                  logic [7:0] b7);
        t_in it;
        it.cmd          = CMD_FRAME;
        it.frame_id     = id;
        it.frame_length = len;
        it.byte0        = b0;
        it.byte1        = b1;
        it.byte2        = b2;
        it.byte3        = b3;
        it.byte4        = b4;
        it.byte5        = b5;
        it.byte6        = b6;
        it.byte7        = b7;
        return it;
    endfunction

    function automatic t_out reply(logic acc, logic [1:0] added, logic [4:0] total,
                                   logic full, logic [15:0] c0, logic [15:0] c1,
                                   logic [15:0] c2);
        t_out r;
        r.frame_accepted  = acc;
        r.codes_added     = added;
        r.total_codes     = total;
        r.list_full       = full;
        r.new_code_first  = c0;
        r.new_code_second = c1;
        r.new_code_third  = c2;
        return r;
    endfunction

    function automatic t_in noise_item();
        t_in         it;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        it  = raw[$bits(t_in)-1:0];
        it.frame_length = $urandom_range(0, 15);
        return it;
    endfunction

    function automatic logic [7:0] code_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return BYTE_INVALID;
            2, 3, 4: return 8'($urandom_range(0, 3));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_in dtc_frame(bit broken);
        t_in it;
        it = frame(ID_LOW + 11'($urandom_range(0, 7)),
                   ($urandom_range(0, 3) == 0) ? 4'($urandom_range(3, 15)) : 4'd8,
                   {4'h0, ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 7)) : 4'd6},
                   SERVICE_OFFSET + req_mode,
                   code_byte(), code_byte(), code_byte(), code_byte(), code_byte(),
                   code_byte());
        if (broken) begin
            case ($urandom_range(0, 4))
                0: it.frame_id      = 11'($urandom_range(0, 2047));
                1: it.frame_length  = 4'($urandom_range(0, 2));
                2: it.byte0[7:4]    = 4'($urandom_range(1, 15));
                3: it.byte0[3:0]    = ($urandom_range(0, 1) == 0) ? 4'd0
                                                                  : 4'($urandom_range(8, 15));
                default: it.byte1   = 8'($urandom_range(0, 255));
            endcase
        end
        return it;
    endfunction

    task automatic send(t_in it, bit typed, t_out typed_reply);
        t_out exp;
        if (gap_on && $urandom_range(0, 5) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data  = it;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        exp = collect_codes(it);
        if (typed) exp = typed_reply;
        replies.push_back(exp);
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic write_mode(logic [7:0] mode);
        in_valid = 1'b0;
        while (replies.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_wdata = mode;
        @(negedge i_clk);
        cfg_we    = 1'b0;
        req_mode  = mode;
        n_modes++;
    endtask

    task automatic report(string field, logic [15:0] e, logic [15:0] a);
        $display("%0t: %s mismatch, expected %h actual %h", $time, field, e, a);
        n_fail++;
    endtask

    // receiver backpressure
    initial begin
        int unsigned hold;
        hold      = 0;
        out_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
                out_ready = 1'b0;
            end else if (stall_on && $urandom_range(0, 7) == 0) begin
                hold      = $urandom_range(0, 5);
                out_ready = 1'b0;
            end else begin
                out_ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out exp;
        if (i_rst_n && out_valid && out_ready) begin
            if (replies.size() == 0) begin
                $display("%0t: unexpected result transfer, actual %h", $time, out_data);
                n_fail++;
            end else begin
                exp = replies.pop_front();
                n_checked++;
                if (out_data.frame_accepted !== exp.frame_accepted)
                    report("frame_accepted", 16'(exp.frame_accepted),
                           16'(out_data.frame_accepted));
                if (out_data.codes_added !== exp.codes_added)
                    report("codes_added", 16'(exp.codes_added), 16'(out_data.codes_added));
                if (out_data.total_codes !== exp.total_codes)
                    report("total_codes", 16'(exp.total_codes), 16'(out_data.total_codes));
                if (out_data.list_full !== exp.list_full)
                    report("list_full", 16'(exp.list_full), 16'(out_data.list_full));
                if (out_data.new_code_first !== exp.new_code_first)
                    report("new_code_first", exp.new_code_first, out_data.new_code_first);
                if (out_data.new_code_second !== exp.new_code_second)
                    report("new_code_second", exp.new_code_second, out_data.new_code_second);
                if (out_data.new_code_third !== exp.new_code_third)
                    report("new_code_third", exp.new_code_third, out_data.new_code_third);
            end
        end
    end

    initial begin
        t_in         start_cmd;
        t_out        none;
        logic [7:0]  svc;
        logic [7:0]  modes [0:5];
        int unsigned target;
        int unsigned run;
        int unsigned pick;

        i_rst_n    = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        gap_on     = 1'b1;
        stall_on   = 1'b1;
        n_fail     = 0;
        n_items    = 0;
        n_checked  = 0;
        n_fills    = 0;
        n_modes    = 1;
        req_mode   = MODE_RESET;
        code_count = 0;
        start_cmd  = '0;
        none       = '0;
        svc        = SERVICE_OFFSET + MODE_RESET;

        table_rows.push_back('{start_cmd, 1'b1, none});
        table_rows.push_back('{frame(11'h7E7, 8, 8'h06, svc, 1, 2, 3, 4, 5, 6), 1'b1, none});
        table_rows.push_back('{frame(11'h7F0, 8, 8'h06, svc, 1, 2, 3, 4, 5, 6), 1'b1, none});
        table_rows.push_back('{frame(11'h000, 8, 8'h06, svc, 1, 2, 3, 4, 5, 6), 1'b1, none});
        table_rows.push_back('{frame(11'h7E8, 2, 8'h06, svc, 1, 2, 3, 4, 5, 6), 1'b1, none});
        table_rows.push_back('{frame(11'h7E8, 8, 8'h16, svc, 1, 2, 3, 4, 5, 6), 1'b1, none});
        table_rows.push_back('{frame(11'h7E8, 8, 8'h00, svc, 1, 2, 3, 4, 5, 6), 1'b1, none});
        table_rows.push_back('{frame(11'h7E8, 8, 8'h08, svc, 1, 2, 3, 4, 5, 6), 1'b1, none});
        table_rows.push_back('{frame(11'h7E8, 8, 8'h06, 8'h42, 1, 2, 3, 4, 5, 6), 1'b1, none});
        table_rows.push_back('{frame(11'h7FF, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                     8'hFF, 8'hFF), 1'b1, none});
        table_rows.push_back('{frame(11'h7E8, 8, 8'h06, svc, 8'h01, 8'h33, 8'h04, 8'h20,
                                     8'hC1, 8'h00),
                               1'b1, reply(1, 3, 3, 0, 16'h0133, 16'h0420, 16'hC100)});
        // duplicates, empty pair, invalid bytes
        table_rows.push_back('{frame(11'h7EF, 8, 8'h06, svc, 8'h01, 8'h33, 8'h04, 8'h20,
                                     8'hC1, 8'h00), 1'b0, none});
        table_rows.push_back('{frame(11'h7EA, 8, 8'h06, svc, 8'h00, 8'h00, 8'hFF, 8'h12,
                                     8'h12, 8'hFF), 1'b0, none});
        // length beyond eight, short payload, frame shorter than payload
        table_rows.push_back('{frame(11'h7E9, 15, 8'h06, svc, 8'h80, 8'h01, 8'h40, 8'h02,
                                      8'h7F, 8'hFE), 1'b0, none});
        table_rows.push_back('{frame(11'h7EB, 8, 8'h03, svc, 8'h11, 8'h11, 8'h22, 8'h22,
                                     8'h33, 8'h33), 1'b0, none});
        table_rows.push_back('{frame(11'h7EC, 5, 8'h07, svc, 8'h44, 8'h44, 8'h55, 8'h55,
                                     8'h66, 8'h66), 1'b0, none});
        table_rows.push_back('{frame(11'h7ED, 3, 8'h07, svc, 8'h77, 8'h77, 8'h78, 8'h78,
                                     8'h79, 8'h79), 1'b0, none});
        // fill the list; last code of the third frame finds it full
        table_rows.push_back('{frame(11'h7EE, 8, 8'h07, svc, 8'hA0, 8'h01, 8'hA0, 8'h02,
                                     8'hA0, 8'h03), 1'b0, none});
        table_rows.push_back('{frame(11'h7EE, 8, 8'h07, svc, 8'hA0, 8'h04, 8'hA0, 8'h05,
                                     8'hA0, 8'h06), 1'b0, none});
        table_rows.push_back('{frame(11'h7EE, 8, 8'h07, svc, 8'hA0, 8'h07, 8'hA0, 8'h08,
                                     8'hA0, 8'h09), 1'b0, none});
        table_rows.push_back('{frame(11'h7E8, 8, 8'h06, svc, 8'hB0, 8'h01, 8'hB0, 8'h02,
                                     8'hB0, 8'h03), 1'b1, reply(0, 0, 16, 1, 0, 0, 0)});
        table_rows.push_back('{start_cmd, 1'b1, none});
        table_rows.push_back('{start_cmd, 1'b1, none});

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (table_rows[i])
            send(table_rows[i].item, table_rows[i].typed, table_rows[i].reply);

        modes[0] = 8'd0;
        modes[1] = 8'd191;
        modes[2] = 8'($urandom_range(0, 191));
        modes[3] = 8'd64;
        modes[4] = 8'($urandom_range(0, 191));
        modes[5] = MODE_RESET;

        for (int p = 0; p < 6; p++) begin
            write_mode(modes[p]);
            target = n_items + PHASE_LEN;
            while (n_items < target) begin
                gap_on   = (p < 5) && ($urandom_range(0, 3) != 0);
                stall_on = (p < 5) && ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 4) != 0) begin
                    start_cmd     = noise_item();
                    start_cmd.cmd = CMD_START;
                    send(start_cmd, 1'b0, none);
                end
                run = $urandom_range(2, 10);
                for (int j = 0; j < run; j++) begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                        send(noise_item(), 1'b0, none);
                    else
                        send(dtc_frame(pick == 1), 1'b0, none);
                end
            end
        end

        in_valid = 1'b0;
        while (replies.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        $display("Sent %0d items under %0d request modes; %0d results checked",
                 n_items, n_modes, n_checked);
        $display("Code list filled to capacity %0d times", n_fills);
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
